[src/tftpc_pkg.sv]
// Package for the TFTP client transfer engine: codes, widths and shared types.
// No dependencies; used by every file of the block but the two interfaces.
package tftpc_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [9:0]  BLOCK_LEN = 10'(BLOCK_BYTES);
  localparam logic [30:0] BLOCK_SZ  = 31'(BLOCK_BYTES);

  // request types
  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_PACKET = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  // received opcodes
  localparam logic [15:0] OP_RRQ   = 16'd1;
  localparam logic [15:0] OP_WRQ   = 16'd2;
  localparam logic [15:0] OP_DATA  = 16'd3;
  localparam logic [15:0] OP_ACK   = 16'd4;
  localparam logic [15:0] OP_ERROR = 16'd5;
  localparam logic [15:0] OP_OACK  = 16'd6;

  // sent packet kinds
  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_RRQ    = 3'd1;
  localparam logic [2:0] KIND_WRQ    = 3'd2;
  localparam logic [2:0] KIND_ACK    = 3'd3;
  localparam logic [2:0] KIND_DATA   = 3'd4;
  localparam logic [2:0] KIND_RESEND = 3'd5;

  // status codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_BUSY = 3'd1;
  localparam logic [2:0] ST_OK   = 3'd2;
  localparam logic [2:0] ST_PEER = 3'd3;
  localparam logic [2:0] ST_EXH  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_DIRECTION_PUT = 2'd0;
  localparam logic [1:0] CFG_FILE_SIZE     = 2'd1;
  localparam logic [1:0] CFG_RETRY_LIMIT   = 2'd2;
  localparam logic [1:0] CFG_TSIZE_ENABLE  = 2'd3;

  typedef enum logic [2:0] {
    CMD_START,
    CMD_IGNORE,
    CMD_TICK,
    CMD_DATA,
    CMD_ACK,
    CMD_ERROR,
    CMD_REQ,
    CMD_OTHER
  } cmd_t;

  // classified word passed from front to back
  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] blk;       // DATA block, or ack block (zero for OACK)
    logic [9:0]  wlen;      // payload length saturated at one block
    logic        short_blk; // payload shorter than a block
  } work_t;

  typedef struct packed {
    logic        direction_put;
    logic [30:0] file_size;
    logic [7:0]  retry_limit;
    logic        tsize_enable;
  } cfg_t;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_BUSY = 5'b00010,
    PH_OK   = 5'b00100,
    PH_PEER = 5'b01000,
    PH_EXH  = 5'b10000
  } phase_t;

endpackage

[src/tftpc_evt_if.sv]
// Event channel of the TFTP client engine: valid/ready plus one event word.
// Depends on nothing.
interface tftpc_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] rx_opcode;
  logic [15:0] rx_block;
  logic [9:0]  rx_payload_len;

  modport source(output valid, req_type, rx_opcode, rx_block, rx_payload_len,
                 input ready);
  modport sink(input valid, req_type, rx_opcode, rx_block, rx_payload_len,
               output ready);
endinterface

[src/tftpc_tx_if.sv]
// Result channel of the TFTP client engine: valid/ready plus one result word.
// Depends on nothing.
interface tftpc_tx_if;
  logic        valid;
  logic        ready;
  logic [2:0]  tx_kind;
  logic [15:0] tx_block;
  logic [9:0]  tx_len;
  logic [30:0] tx_file_offset;
  logic        tx_tsize;
  logic [9:0]  write_len;
  logic [2:0]  status;

  modport source(output valid, tx_kind, tx_block, tx_len, tx_file_offset, tx_tsize,
                 write_len, status, input ready);
  modport sink(input valid, tx_kind, tx_block, tx_len, tx_file_offset, tx_tsize,
               write_len, status, output ready);
endinterface

[src/tftpc_front.sv]
// Front end: takes event words and classifies them into work words for the queue.
// Depends on tftpc_pkg and tftpc_evt_if.
module tftpc_front (
  tftpc_evt_if.sink       evt,
  input  logic            q_full,
  output logic            q_push,
  output tftpc_pkg::work_t q_data
);

  assign evt.ready = !q_full;
  assign q_push    = evt.valid && !q_full;

  always_comb begin
    q_data.blk       = evt.rx_block;
    q_data.wlen      = (evt.rx_payload_len > tftpc_pkg::BLOCK_LEN) ?
                       tftpc_pkg::BLOCK_LEN : evt.rx_payload_len;
    q_data.short_blk = evt.rx_payload_len < tftpc_pkg::BLOCK_LEN;
    q_data.cmd       = tftpc_pkg::CMD_IGNORE;
    case (evt.req_type)
      tftpc_pkg::REQ_START:  q_data.cmd = tftpc_pkg::CMD_START;
      tftpc_pkg::REQ_TICK:   q_data.cmd = tftpc_pkg::CMD_TICK;
      tftpc_pkg::REQ_PACKET: begin
        case (evt.rx_opcode)
          tftpc_pkg::OP_DATA:  q_data.cmd = tftpc_pkg::CMD_DATA;
          tftpc_pkg::OP_ACK:   q_data.cmd = tftpc_pkg::CMD_ACK;
          tftpc_pkg::OP_OACK: begin
            q_data.cmd = tftpc_pkg::CMD_ACK;
            q_data.blk = '0; // OACK acks block zero
          end
          tftpc_pkg::OP_ERROR: q_data.cmd = tftpc_pkg::CMD_ERROR;
          tftpc_pkg::OP_RRQ,
          tftpc_pkg::OP_WRQ:   q_data.cmd = tftpc_pkg::CMD_REQ;
          default:             q_data.cmd = tftpc_pkg::CMD_OTHER;
        endcase
      end
      default: q_data.cmd = tftpc_pkg::CMD_IGNORE;
    endcase
  end

endmodule

[src/tftpc_queue.sv]
// Short FIFO of work words between the front end and the back end.
// Depends on tftpc_pkg.
module tftpc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tftpc_pkg::work_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output tftpc_pkg::work_t pop_data
);

  tftpc_pkg::work_t                 entries [tftpc_pkg::QUEUE_DEPTH];
  logic [tftpc_pkg::QPTR_W-1:0]     wr_ptr;
  logic [tftpc_pkg::QPTR_W-1:0]     rd_ptr;
  logic [tftpc_pkg::QCNT_W-1:0]     count;

  assign full      = count == tftpc_pkg::QCNT_W'(tftpc_pkg::QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign pop_data  = entries[rd_ptr];

  function automatic logic [tftpc_pkg::QPTR_W-1:0] ptr_inc(
      input logic [tftpc_pkg::QPTR_W-1:0] p);
    if (p == tftpc_pkg::QPTR_W'(tftpc_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/tftpc_back.sv]
// Back end: transfer state and packet sequencing, one work word per cycle
// unless tx stalls, registered result word. Needs tftpc_pkg, tftpc_tx_if.
module tftpc_back (
  input  logic             clk,
  input  logic             rst,
  input  tftpc_pkg::cfg_t  cfg,
  input  logic             q_valid,
  input  tftpc_pkg::work_t q_data,
  output logic             q_pop,
  tftpc_tx_if.source       tx
);

  logic [30:0]       remaining, remaining_next;
  logic              final_sent, final_sent_next;
  logic [30:0]       send_offset, send_offset_next;
  logic [15:0]       prev_ack, prev_ack_next;
  logic [7:0]        tcount, tcount_next;
  tftpc_pkg::phase_t phase, phase_next;
  logic [2:0]        last_kind, last_kind_next;
  logic [15:0]       last_blk, last_blk_next;
  logic [9:0]        last_len, last_len_next;

  logic        out_valid;
  logic [2:0]  r_kind;
  logic [15:0] r_blk;
  logic [9:0]  r_len;
  logic [30:0] r_off;
  logic        r_tsize;
  logic [9:0]  r_wlen;
  logic [2:0]  r_status;

  logic [30:0] resend_off;
  logic        resend_tsize;
  logic [7:0]  tcount_inc;
  logic [15:0] blk_plus;
  logic        in_seq;

  assign q_pop = q_valid && (!out_valid || tx.ready);

  assign resend_off   = (last_kind == tftpc_pkg::KIND_DATA) ?
                        (send_offset - {21'd0, last_len}) : '0;
  assign resend_tsize = (last_kind == tftpc_pkg::KIND_WRQ) && cfg.tsize_enable;
  assign tcount_inc   = (tcount == 8'hFF) ? tcount : tcount + 8'd1;
  assign blk_plus     = q_data.blk + 16'd1;
  assign in_seq       = (q_data.blk == '0) || (q_data.blk == prev_ack + 16'd1);

  always_comb begin
    remaining_next   = remaining;
    final_sent_next  = final_sent;
    send_offset_next = send_offset;
    prev_ack_next    = prev_ack;
    tcount_next      = tcount;
    phase_next       = phase;
    last_kind_next   = last_kind;
    last_blk_next    = last_blk;
    last_len_next    = last_len;
    r_kind  = tftpc_pkg::KIND_NONE;
    r_blk   = '0;
    r_len   = '0;
    r_off   = '0;
    r_tsize = 1'b0;
    r_wlen  = '0;

    if (q_data.cmd == tftpc_pkg::CMD_START) begin
      r_kind           = cfg.direction_put ? tftpc_pkg::KIND_WRQ : tftpc_pkg::KIND_RRQ;
      r_tsize          = cfg.direction_put && cfg.tsize_enable;
      remaining_next   = cfg.direction_put ? cfg.file_size : '0;
      final_sent_next  = 1'b0;
      send_offset_next = '0;
      prev_ack_next    = '0;
      tcount_next      = '0;
      phase_next       = tftpc_pkg::PH_BUSY;
      last_kind_next   = r_kind;
      last_blk_next    = '0;
      last_len_next    = '0;
    end else if (phase == tftpc_pkg::PH_BUSY) begin
      case (q_data.cmd)
        tftpc_pkg::CMD_TICK: begin
          tcount_next = tcount_inc;
          if (tcount_inc >= cfg.retry_limit) begin
            phase_next = tftpc_pkg::PH_EXH;
          end else begin
            r_kind  = tftpc_pkg::KIND_RESEND;
            r_blk   = last_blk;
            r_len   = last_len;
            r_off   = resend_off;
            r_tsize = resend_tsize;
          end
        end
        tftpc_pkg::CMD_DATA: begin
          tcount_next    = '0;
          last_kind_next = tftpc_pkg::KIND_ACK;
          last_blk_next  = q_data.blk;
          last_len_next  = '0;
          if (q_data.short_blk) begin
            phase_next = tftpc_pkg::PH_OK;
          end
          r_kind = tftpc_pkg::KIND_ACK;
          r_blk  = q_data.blk;
          r_wlen = q_data.wlen;
        end
        tftpc_pkg::CMD_ACK: begin
          if (final_sent) begin
            phase_next = tftpc_pkg::PH_OK;
          end else begin
            tcount_next   = '0;
            prev_ack_next = q_data.blk;
            if (in_seq) begin
              if (remaining >= tftpc_pkg::BLOCK_SZ) begin
                r_len          = tftpc_pkg::BLOCK_LEN;
                remaining_next = remaining - tftpc_pkg::BLOCK_SZ;
              end else begin
                r_len           = remaining[9:0];
                remaining_next  = '0;
                final_sent_next = 1'b1;
              end
              r_kind           = tftpc_pkg::KIND_DATA;
              r_blk            = blk_plus;
              r_off            = send_offset;
              send_offset_next = send_offset + {21'd0, r_len};
              last_kind_next   = tftpc_pkg::KIND_DATA;
              last_blk_next    = blk_plus;
              last_len_next    = r_len;
            end else begin
              r_kind  = tftpc_pkg::KIND_RESEND;
              r_blk   = last_blk;
              r_len   = last_len;
              r_off   = resend_off;
              r_tsize = resend_tsize;
            end
          end
        end
        tftpc_pkg::CMD_ERROR: phase_next = tftpc_pkg::PH_PEER;
        tftpc_pkg::CMD_OTHER: phase_next = tftpc_pkg::PH_OK;
        default: ; // stray requests and ignored words send nothing
      endcase
    end
  end

  always_comb begin
    case (phase_next)
      tftpc_pkg::PH_IDLE: r_status = tftpc_pkg::ST_IDLE;
      tftpc_pkg::PH_BUSY: r_status = tftpc_pkg::ST_BUSY;
      tftpc_pkg::PH_OK:   r_status = tftpc_pkg::ST_OK;
      tftpc_pkg::PH_PEER: r_status = tftpc_pkg::ST_PEER;
      tftpc_pkg::PH_EXH:  r_status = tftpc_pkg::ST_EXH;
      default:            r_status = tftpc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining   <= '0;
      final_sent  <= 1'b0;
      send_offset <= '0;
      prev_ack    <= '0;
      tcount      <= '0;
      phase       <= tftpc_pkg::PH_IDLE;
      last_kind   <= tftpc_pkg::KIND_NONE;
      last_blk    <= '0;
      last_len    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (q_pop) begin
        remaining   <= remaining_next;
        final_sent  <= final_sent_next;
        send_offset <= send_offset_next;
        prev_ack    <= prev_ack_next;
        tcount      <= tcount_next;
        phase       <= phase_next;
        last_kind   <= last_kind_next;
        last_blk    <= last_blk_next;
        last_len    <= last_len_next;
        out_valid   <= 1'b1;
      end else if (tx.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      tx.tx_kind        <= r_kind;
      tx.tx_block       <= r_blk;
      tx.tx_len         <= r_len;
      tx.tx_file_offset <= r_off;
      tx.tx_tsize       <= r_tsize;
      tx.write_len      <= r_wlen;
      tx.status         <= r_status;
    end
  end

  assign tx.valid = out_valid;

endmodule

[src/tftpc_client_top.sv]
// TFTP client transfer engine, top level: configuration registers, front end,
// work queue and back end. Depends on tftpc_pkg and both channel interfaces.
//
// Usage: events (start, packet received, timeout tick) enter on the evt channel,
// one word per valid/ready handshake. Every event yields exactly one result word
// on the tx channel: the packet to send (or none), its block, length and file
// offset, the byte count to store on a get, and the transfer status.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Flow: an accepted word is classified and written into a two-entry queue; the
// back end pops it into the result register when that register is empty or its
// word is being taken. Throughput: one event per cycle while the receiver takes
// every result; the back end updates the transfer state as it pops each word.
// When the receiver stalls, the result register holds and the queue fills; evt
// ready drops only when both queue entries are taken.
// Reset (rst, synchronous) empties the queue and the result register, puts the
// transfer in idle and loads the register defaults (get, size 0, retry limit 8,
// tsize on).
module tftp_client_transfer_engine_top (
  input  logic        clk,
  input  logic        rst,
  tftpc_evt_if.sink   evt,
  tftpc_tx_if.source  tx,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  tftpc_pkg::cfg_t  cfg;
  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_valid;
  tftpc_pkg::work_t q_in;
  tftpc_pkg::work_t q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.direction_put <= 1'b0;
      cfg.file_size     <= '0;
      cfg.retry_limit   <= 8'd8;
      cfg.tsize_enable  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        tftpc_pkg::CFG_DIRECTION_PUT: cfg.direction_put <= cfg_data[0];
        tftpc_pkg::CFG_FILE_SIZE:     cfg.file_size     <= cfg_data;
        tftpc_pkg::CFG_RETRY_LIMIT:   cfg.retry_limit   <= cfg_data[7:0];
        tftpc_pkg::CFG_TSIZE_ENABLE:  cfg.tsize_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tftpc_front u_front (
    .evt    (evt),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  tftpc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_out)
  );

  tftpc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .tx      (tx)
  );

endmodule

[bench/tftp_client_transfer_engine_top_tb.sv]
// Self-checking bench for the TFTP client transfer engine: directed table, then random transfers.
// An in-bench model of the transfer predicts each result word.
// Depends on tftpc_pkg, tftpc_evt_if, tftpc_tx_if and tftp_client_transfer_engine_top.
module tftp_client_transfer_engine_top_tb;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_TARGET = 650;

  typedef struct packed {
    logic [1:0]  req;
    logic [15:0] op;
    logic [15:0] blk;
    logic [9:0]  plen;
  } evt_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] blk;
    logic [9:0]  len;
    logic [30:0] off;
    logic        tsize;
    logic [9:0]  wlen;
    logic [2:0]  status;
  } tx_word_t;

  typedef struct {
    bit         is_cfg;
    logic [1:0] reg_idx;
    logic [30:0] reg_val;
    evt_word_t  ev;
    bit         typed;
    tx_word_t   want;
  } step_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [30:0] cfg_data;

  tftpc_evt_if evt_ch();
  tftpc_tx_if  tx_ch();

  tftp_client_transfer_engine_top dut (
    .clk(clk),
    .rst(rst),
    .evt(evt_ch),
    .tx(tx_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // model copy of the registers
  logic        cfg_put   = 1'b0;
  logic [30:0] cfg_size  = '0;
  logic [7:0]  cfg_retry = 8'd8;
  logic        cfg_tsize = 1'b1;

  // model copy of the transfer state
  logic [2:0]  xfer_phase = tftpc_pkg::ST_IDLE;
  logic [30:0] bytes_left = '0;
  logic        final_sent = 1'b0;
  logic [30:0] send_off   = '0;
  logic [15:0] prev_ack   = '0;
  logic [7:0]  tick_count = '0;
  logic [2:0]  last_kind  = tftpc_pkg::KIND_NONE;
  logic [15:0] last_blk   = '0;
  logic [9:0]  last_len   = '0;

  tx_word_t expected_tx[$];
  step_t    plan[$];

  int live_items, sent_items, checked_words, transfers, mismatches;
  int evt_calm, sink_calm;
  tx_word_t got;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("tftp_client_transfer_engine_top regression: fail");
    $finish;
  end

  function automatic int pause_len(inout int calm);
    int n;
    n = 0;
    if (calm > 0) calm--;
    else if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 40);
    else n = $urandom_range(0, 6);
    return n;
  endfunction

  function automatic void note_sent(logic [2:0] kind, logic [15:0] blk, logic [9:0] len);
    last_kind = kind;
    last_blk  = blk;
    last_len  = len;
  endfunction

  function automatic tx_word_t resend_word();
    tx_word_t w;
    w = '0;
    w.kind = tftpc_pkg::KIND_RESEND;
    w.blk  = last_blk;
    w.len  = last_len;
    if (last_kind == tftpc_pkg::KIND_DATA) w.off = send_off - 31'(last_len);
    if (last_kind == tftpc_pkg::KIND_WRQ && cfg_tsize) w.tsize = 1'b1;
    return w;
  endfunction

  // advances the transfer by one event and returns the word the engine must emit
  function automatic tx_word_t next_tx_word(evt_word_t e);
    tx_word_t    w;
    logic [15:0] ab;
    logic [9:0]  dlen;
    w = '0;
    if (e.req == tftpc_pkg::REQ_START) begin
      w.kind     = cfg_put ? tftpc_pkg::KIND_WRQ : tftpc_pkg::KIND_RRQ;
      w.tsize    = cfg_put & cfg_tsize;
      bytes_left = cfg_put ? cfg_size : '0;
      final_sent = 1'b0;
      send_off   = '0;
      prev_ack   = '0;
      tick_count = '0;
      xfer_phase = tftpc_pkg::ST_BUSY;
      note_sent(w.kind, '0, '0);
    end else if (xfer_phase == tftpc_pkg::ST_BUSY && e.req == tftpc_pkg::REQ_TICK) begin
      if (tick_count != 8'hFF) tick_count++;
      if (tick_count >= cfg_retry) xfer_phase = tftpc_pkg::ST_EXH;
      else w = resend_word();
    end else if (xfer_phase == tftpc_pkg::ST_BUSY && e.req == tftpc_pkg::REQ_PACKET) begin
      case (e.op)
        tftpc_pkg::OP_DATA: begin
          w.kind     = tftpc_pkg::KIND_ACK;
          w.blk      = e.blk;
          w.wlen     = (e.plen > tftpc_pkg::BLOCK_LEN) ? tftpc_pkg::BLOCK_LEN : e.plen;
          tick_count = '0;
          note_sent(tftpc_pkg::KIND_ACK, e.blk, '0);
          if (e.plen < tftpc_pkg::BLOCK_LEN) xfer_phase = tftpc_pkg::ST_OK;
        end
        tftpc_pkg::OP_ACK, tftpc_pkg::OP_OACK: begin
          ab = (e.op == tftpc_pkg::OP_ACK) ? e.blk : 16'd0;
          if (final_sent) begin
            xfer_phase = tftpc_pkg::ST_OK;
          end else begin
            tick_count = '0;
            if (ab == 16'd0 || ab == prev_ack + 16'd1) begin
              if (bytes_left > tftpc_pkg::BLOCK_SZ) begin
                dlen = tftpc_pkg::BLOCK_LEN;
                bytes_left = bytes_left - tftpc_pkg::BLOCK_SZ;
              end else begin
                // a short (or empty) block closes the put; an exact block does not
                dlen = bytes_left[9:0];
                if (bytes_left != tftpc_pkg::BLOCK_SZ) final_sent = 1'b1;
                bytes_left = '0;
              end
              w.kind   = tftpc_pkg::KIND_DATA;
              w.blk    = ab + 16'd1;
              w.len    = dlen;
              w.off    = send_off;
              send_off = send_off + 31'(dlen);
              note_sent(tftpc_pkg::KIND_DATA, ab + 16'd1, dlen);
            end else begin
              w = resend_word();
            end
            prev_ack = ab;
          end
        end
        tftpc_pkg::OP_ERROR: xfer_phase = tftpc_pkg::ST_PEER;
        tftpc_pkg::OP_RRQ, tftpc_pkg::OP_WRQ: ;
        default: xfer_phase = tftpc_pkg::ST_OK;
      endcase
    end
    w.status = xfer_phase;
    return w;
  endfunction

  function automatic string show(tx_word_t w);
    return $sformatf("kind %0d blk %0d len %0d off %0d tsize %0d wlen %0d status %0d",
                     w.kind, w.blk, w.len, w.off, w.tsize, w.wlen, w.status);
  endfunction

  function automatic step_t ev_step(logic [1:0] req, logic [15:0] op, logic [15:0] blk,
                                    logic [9:0] plen);
    step_t s;
    s = '{default: '0};
    s.ev = {req, op, blk, plen};
    return s;
  endfunction

  function automatic step_t chk_step(logic [1:0] req, logic [15:0] op, logic [15:0] blk,
                                     logic [9:0] plen, logic [2:0] kind, logic [15:0] tblk,
                                     logic [9:0] tlen, logic [30:0] toff, logic ts,
                                     logic [9:0] wl, logic [2:0] st);
    step_t s;
    s = ev_step(req, op, blk, plen);
    s.typed = 1'b1;
    s.want  = {kind, tblk, tlen, toff, ts, wl, st};
    return s;
  endfunction

  function automatic step_t cfg_step(logic [1:0] idx, logic [30:0] val);
    step_t s;
    s = '{default: '0};
    s.is_cfg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  // registers change only once every pending word has come back
  task automatic cfg_write(logic [1:0] idx, logic [30:0] val);
    evt_ch.valid = 1'b0;
    wait (expected_tx.size() == 0);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      tftpc_pkg::CFG_DIRECTION_PUT: cfg_put   = val[0];
      tftpc_pkg::CFG_FILE_SIZE:     cfg_size  = val;
      tftpc_pkg::CFG_RETRY_LIMIT:   cfg_retry = val[7:0];
      tftpc_pkg::CFG_TSIZE_ENABLE:  cfg_tsize = val[0];
      default: ;
    endcase
  endtask

  task automatic send_event(evt_word_t e, bit typed, tx_word_t want);
    int       n;
    tx_word_t w;
    n = pause_len(evt_calm);
    if (n > 0) begin
      evt_ch.valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    evt_ch.req_type       = e.req;
    evt_ch.rx_opcode      = e.op;
    evt_ch.rx_block       = e.blk;
    evt_ch.rx_payload_len = e.plen;
    evt_ch.valid          = 1'b1;
    do @(posedge clk); while (!evt_ch.ready);
    if (e.req == tftpc_pkg::REQ_START ||
        (xfer_phase == tftpc_pkg::ST_BUSY && e.req != REQ_UNUSED)) live_items++;
    sent_items++;
    w = next_tx_word(e);
    expected_tx.push_back(typed ? want : w);
    @(negedge clk);
  endtask

  task automatic run_transfer();
    evt_word_t   e;
    int          steps;
    int          r;
    logic [30:0] sz;
    if ($urandom_range(0, 1))
      cfg_write(tftpc_pkg::CFG_DIRECTION_PUT, 31'($urandom_range(0, 1)));
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 7))
        0:       sz = '0;
        1, 2, 3: sz = 31'($urandom_range(1, 2600));
        4, 5:    sz = 31'(512 * $urandom_range(1, 4));
        6:       sz = 31'($urandom_range(2601, 20000));
        default: sz = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'($urandom());
      endcase
      cfg_write(tftpc_pkg::CFG_FILE_SIZE, sz);
    end
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(0, 7);
      cfg_write(tftpc_pkg::CFG_RETRY_LIMIT, (r == 0) ? 31'd1 : (r == 1) ? 31'd255
                                            : 31'($urandom_range(2, 6)));
    end
    if ($urandom_range(0, 1))
      cfg_write(tftpc_pkg::CFG_TSIZE_ENABLE, 31'($urandom_range(0, 1)));
    transfers++;

    e = '0;
    e.req = tftpc_pkg::REQ_START;
    send_event(e, 1'b0, '0);
    steps = 0;
    while (xfer_phase == tftpc_pkg::ST_BUSY && steps < 40) begin
      steps++;
      r = $urandom_range(0, 99);
      e = '0;
      e.req = tftpc_pkg::REQ_PACKET;
      if (r < 8) begin
        e.req = tftpc_pkg::REQ_TICK;
      end else if (r < 14) begin
        e.req  = 2'($urandom_range(0, 3));
        e.op   = $urandom_range(0, 1) ? 16'($urandom_range(0, 7)) : 16'($urandom());
        e.blk  = 16'($urandom());
        e.plen = 10'($urandom_range(0, 1023));
      end else if (r < 16) begin
        e.op = tftpc_pkg::OP_ERROR;
      end else if (r < 18) begin
        e.op = $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom_range(7, 65535));
      end else if (cfg_put) begin
        if (last_kind == tftpc_pkg::KIND_WRQ) begin
          e.op  = $urandom_range(0, 1) ? tftpc_pkg::OP_OACK : tftpc_pkg::OP_ACK;
          e.blk = (e.op == tftpc_pkg::OP_OACK) ? 16'($urandom()) : 16'd0;
        end else if (r < 24) begin
          // out of sequence; near the top so the block number wraps later
          e.op  = tftpc_pkg::OP_ACK;
          e.blk = $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(65534, 65535));
        end else begin
          e.op  = tftpc_pkg::OP_ACK;
          e.blk = prev_ack + 16'd1;
        end
      end else begin
        e.op  = tftpc_pkg::OP_DATA;
        e.blk = last_blk + 16'd1;
        r = $urandom_range(0, 99);
        e.plen = (r < 88) ? 10'd512 : (r < 95) ? 10'($urandom_range(0, 511))
                                                : 10'($urandom_range(513, 1023));
      end
      send_event(e, 1'b0, '0);
    end
    // stray words after the end get a result word with no packet from the engine
    if (xfer_phase != tftpc_pkg::ST_BUSY && $urandom_range(0, 3) == 0) begin
      e = '0;
      e.req = $urandom_range(0, 1) ? tftpc_pkg::REQ_TICK : tftpc_pkg::REQ_PACKET;
      e.op  = tftpc_pkg::OP_ACK;
      send_event(e, 1'b0, '0);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && tx_ch.valid && tx_ch.ready) begin
      got = {tx_ch.tx_kind, tx_ch.tx_block, tx_ch.tx_len, tx_ch.tx_file_offset,
             tx_ch.tx_tsize, tx_ch.write_len, tx_ch.status};
      checked_words++;
      if (expected_tx.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: unexpected word: %s", $time, show(got));
      end else if (got !== expected_tx[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch\n  want %s\n  got  %s", $time, show(expected_tx[0]),
                   show(got));
        void'(expected_tx.pop_front());
      end else begin
        void'(expected_tx.pop_front());
      end
    end
  end

  // receiver side
  initial begin
    int n;
    tx_ch.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      n = pause_len(sink_calm);
      if (n > 0) begin
        tx_ch.ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      tx_ch.ready = 1'b1;
      do @(posedge clk); while (!tx_ch.valid);
      @(negedge clk);
    end
  end

  initial begin
    evt_ch.valid          = 1'b0;
    evt_ch.req_type       = tftpc_pkg::REQ_START;
    evt_ch.rx_opcode      = '0;
    evt_ch.rx_block       = '0;
    evt_ch.rx_payload_len = '0;
    cfg_we    = 1'b0;
    cfg_index = tftpc_pkg::CFG_DIRECTION_PUT;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // idle engine ignores everything but a start
    plan.push_back(chk_step(tftpc_pkg::REQ_TICK, 16'd0, 16'd0, 10'd0,
      tftpc_pkg::KIND_NONE, 16'd0, 10'd0, 31'd0, 1'b0, 10'd0, tftpc_pkg::ST_IDLE));
    plan.push_back(chk_step(tftpc_pkg::REQ_PACKET, tftpc_pkg::OP_DATA, 16'd1, 10'd512,
      tftpc_pkg::KIND_NONE, 16'd0, 10'd0, 31'd0, 1'b0, 10'd0, tftpc_pkg::ST_IDLE));
    plan.push_back(chk_step(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 10'h3FF,
      tftpc_pkg::KIND_NONE, 16'd0, 10'd0, 31'd0, 1'b0, 10'd0, tftpc_pkg::ST_IDLE));
    // get with reset registers
    plan.push_back(chk_step(tftpc_pkg::REQ_START, 16'd0, 16'd0, 10'd0,
      tftpc_pkg::KIND_RRQ, 16'd0, 10'd0, 31'd0, 1'b0, 10'd0, tftpc_pkg::ST_BUSY));
    plan.push_back(chk_step(tftpc_pkg::REQ_PACKET, tftpc_pkg::OP_DATA, 16'd1, 10'd512,
      tftpc_pkg::KIND_ACK, 16'd1, 10'd0, 31'd0, 1'b0, 10'd512, tftpc_pkg::ST_BUSY));
    plan.push_back(chk_step(tftpc_pkg::REQ_PACKET, tftpc_pkg::OP_DATA, 16'hFFFF, 10'h3FF,
      tftpc_pkg::KIND_ACK, 16'hFFFF, 10'd0, 31'd0, 1'b0, 10'd512, tftpc_pkg::ST_BUSY));
    plan.push_back(ev_step(tftpc_pkg::REQ_PACKET, tftpc_pkg::OP_RRQ, 16'd3, 10'd0));
    plan.push_back(ev_step(tftpc_pkg::REQ_PACKET, tftpc_pkg::OP_WRQ, 16'd3, 10'd0));
    plan.push_back(ev_step(tftpc_pkg::REQ_TICK, 16'd0, 16'd0, 10'd0));
    // empty final block, then an ack after it
    plan.push_back(ev_step(tftpc_pkg::REQ_PACKET, tftpc_pkg::OP_ACK, 16'd0, 10'd0));
    plan.push_back(ev_step(tftpc_pkg::REQ_PACKET, tftpc_pkg::OP_ACK, 16'd7, 10'd0));
    // put of 1000 bytes, two retries
    plan.push_back(cfg_step(tftpc_pkg::CFG_DIRECTION_PUT, 31'd1));
    plan.push_back(cfg_step(tftpc_pkg::CFG_FILE_SIZE, 31'd1000));
    plan.push_back(cfg_step(tftpc_pkg::CFG_RETRY_LIMIT, 31'd2));
    plan.push_back(chk_step(tftpc_pkg::REQ_START, 16'd0, 16'd0, 10'd0,
      tftpc_pkg::KIND_WRQ, 16'd0, 10'd0, 31'd0, 1'b1, 10'd0, tftpc_pkg::ST_BUSY));
    plan.push_back(ev_step(tftpc_pkg::REQ_TICK, 16'd0, 16'd0, 10'd0));
    plan.push_back(ev_step(tftpc_pkg::REQ_PACKET, tftpc_pkg::OP_OACK, 16'hFFFF, 10'd0));
    // out of sequence, then back in sequence
    plan.push_back(ev_step(tftpc_pkg::REQ_PACKET, tftpc_pkg::OP_ACK, 16'd5, 10'd0));
    plan.push_back(ev_step(tftpc_pkg::REQ_PACKET, tftpc_pkg::OP_ACK, 16'd6, 10'd0));
    plan.push_back(ev_step(tftpc_pkg::REQ_TICK, 16'd0, 16'd0, 10'd0));
    plan.push_back(chk_step(tftpc_pkg::REQ_TICK, 16'd0, 16'd0, 10'd0,
      tftpc_pkg::KIND_NONE, 16'd0, 10'd0, 31'd0, 1'b0, 10'd0, tftpc_pkg::ST_EXH));
    plan.push_back(ev_step(tftpc_pkg::REQ_START, 16'd0, 16'd0, 10'd0));
    plan.push_back(chk_step(tftpc_pkg::REQ_PACKET, tftpc_pkg::OP_ERROR, 16'd0, 10'd0,
      tftpc_pkg::KIND_NONE, 16'd0, 10'd0, 31'd0, 1'b0, 10'd0, tftpc_pkg::ST_PEER));
    plan.push_back(ev_step(tftpc_pkg::REQ_START, 16'd0, 16'd0, 10'd0));
    plan.push_back(chk_step(tftpc_pkg::REQ_PACKET, 16'hFFFF, 16'd0, 10'd0,
      tftpc_pkg::KIND_NONE, 16'd0, 10'd0, 31'd0, 1'b0, 10'd0, tftpc_pkg::ST_OK));
    // smallest retry limit, largest file, no tsize
    plan.push_back(cfg_step(tftpc_pkg::CFG_RETRY_LIMIT, 31'd1));
    plan.push_back(cfg_step(tftpc_pkg::CFG_TSIZE_ENABLE, 31'd0));
    plan.push_back(cfg_step(tftpc_pkg::CFG_FILE_SIZE, 31'h7FFF_FFFF));
    plan.push_back(chk_step(tftpc_pkg::REQ_START, 16'd0, 16'd0, 10'd0,
      tftpc_pkg::KIND_WRQ, 16'd0, 10'd0, 31'd0, 1'b0, 10'd0, tftpc_pkg::ST_BUSY));
    plan.push_back(chk_step(tftpc_pkg::REQ_TICK, 16'd0, 16'd0, 10'd0,
      tftpc_pkg::KIND_NONE, 16'd0, 10'd0, 31'd0, 1'b0, 10'd0, tftpc_pkg::ST_EXH));
    plan.push_back(cfg_step(tftpc_pkg::CFG_RETRY_LIMIT, 31'd255));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) cfg_write(plan[i].reg_idx, plan[i].reg_val);
      else send_event(plan[i].ev, plan[i].typed, plan[i].want);
    end

    while (sent_items < RANDOM_TARGET) run_transfer();

    evt_ch.valid = 1'b0;
    wait (expected_tx.size() == 0);
    repeat (8) @(posedge clk);
    $display("ran %0d transfers, %0d event words (%0d acted on), %0d result words checked",
             transfers, sent_items, live_items, checked_words);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0 && expected_tx.size() == 0) begin
      $display("tftp_client_transfer_engine_top regression: pass");
    end else begin
      $display("tftp_client_transfer_engine_top regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
src/tftpc_pkg.sv
src/tftpc_evt_if.sv
src/tftpc_tx_if.sv
src/tftpc_front.sv
src/tftpc_queue.sv
src/tftpc_back.sv
src/tftpc_client_top.sv
bench/tftp_client_transfer_engine_top_tb.sv
